// File: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Assertion macros used by the ALU top module; NO_ASSERTIONS compiles them out
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef NO_ASSERTIONS

// property that must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");

// implication checked in the same cycle outside reset
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLY(lbl, clk, rst, ante, cons)

`endif

`endif

// File: hdl/adcsbc_pkg.sv
// ----------------------------------------------------------------------------
// adcsbc_pkg
// Types and constants of the binary/decimal add and subtract unit
// ----------------------------------------------------------------------------
package adcsbc_pkg;

   localparam int ACC_W      = 16;
   localparam int BYTE_W     = 8;
   localparam int NIBBLE_W   = 4;
   localparam int DIGITS     = ACC_W / NIBBLE_W;
   localparam int DIGITS_NAR = BYTE_W / NIBBLE_W;

   // decimal digit limits and adjust values
   localparam logic [4:0] DEC_MAX     = 5'd9;
   localparam logic [3:0] DEC_ADD_ADJ = 4'd6;
   localparam logic [3:0] DEC_SUB_ADJ = 4'd10;

   // operation codes
   localparam logic OP_ADC = 1'b0;
   localparam logic OP_SBC = 1'b1;

   // one request transaction
   typedef struct packed {
      logic             op;
      logic             wide;
      logic [ACC_W-1:0] acc_in;
      logic [ACC_W-1:0] operand;
      logic             cin_flag;
      logic             decimal;
      logic             overflow_in;
   } req_type;

   // one response transaction
   typedef struct packed {
      logic [ACC_W-1:0] acc_out;
      logic             cout_flag;
      logic             zero_flag;
      logic             negative_flag;
      logic             overflow_out;
   } rsp_type;

endpackage

// File: hdl/adc_sbc_binary_decimal_alu.sv
// ----------------------------------------------------------------------------
// adc_sbc_binary_decimal_alu
// 8/16-bit add with carry and subtract with borrow, binary or BCD
// ----------------------------------------------------------------------------
//   channel    ports                        direction  handshake
//   request    start, busy, req_data        in         start && !busy
//   response   rsp_strobe, rsp_data         out        rsp_strobe, one cycle
//
// One transaction is accepted every cycle; busy is never raised.
// The path runs through an input register, then the adder with its nibble
// adjust chain, then the result register.
// Reset clears only the valid bits of the two register stages.
// The receiver cannot stall, so the pipeline never holds.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module adc_sbc_binary_decimal_alu
   import adcsbc_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    start,
   output logic    busy,
   input  req_type req_data,
   output logic    rsp_strobe,
   output rsp_type rsp_data
);

   req_type req_ff;
   req_type req_in;
   logic    req_valid_ff;
   logic    req_valid_in;
   rsp_type rsp_ff;
   rsp_type rsp_in;
   logic    rsp_valid_ff;
   logic    rsp_valid_in;

   assign busy = 1'b0;

   // input register
   assign req_valid_in = start && !busy;
   assign req_in       = req_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         req_valid_ff <= 1'b0;
      end else begin
         req_valid_ff <= req_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid_in) begin
         req_ff <= req_in;
      end
   end

   // arithmetic
   adcsbc_core u_core (
      .req (req_ff),
      .rsp (rsp_in)
   );

   // result register
   assign rsp_valid_in = req_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (rsp_valid_in) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_strobe = rsp_valid_ff;
   assign rsp_data   = rsp_ff;

   // checks
   `ASSERT_IMPLY(a_rsp_from_req, clock, reset, rsp_strobe, $past(start, 2))
   `ASSERT_IMPLY(a_narrow_keeps_high, clock, reset, rsp_strobe && !$past(req_data.wide, 2), rsp_data.acc_out[ACC_W-1:BYTE_W] == $past(req_data.acc_in[ACC_W-1:BYTE_W], 2))
   `ASSERT_IMPLY(a_decimal_keeps_v, clock, reset, rsp_strobe && $past(req_data.decimal, 2), rsp_data.overflow_out == $past(req_data.overflow_in, 2))
   `ASSERT_IMPLY(a_zero_low_byte, clock, reset, rsp_strobe && rsp_data.zero_flag, rsp_data.acc_out[BYTE_W-1:0] == '0)

endmodule

// File: hdl/adcsbc_core.sv
// ----------------------------------------------------------------------------
// adcsbc_core
// Combinational binary and BCD add/subtract with flag generation
// ----------------------------------------------------------------------------
module adcsbc_core
   import adcsbc_pkg::*;
(
   input  req_type req,
   output rsp_type rsp
);

   logic [ACC_W-1:0] a_m;
   logic [ACC_W-1:0] m_m;
   logic [ACC_W-1:0] rhs;
   logic [ACC_W:0]   bin_sum;
   logic [ACC_W-1:0] bin_res;
   logic             bin_cout;
   logic             v16;
   logic             v8;
   logic             bin_v;
   logic [ACC_W-1:0] dec_res;
   logic             dec_k_nar;
   logic             dec_k_wide;
   logic             dec_cout;
   logic [ACC_W-1:0] res;
   logic             sub;

   assign sub = (req.op == OP_SBC);

   // operands masked to the active width
   assign a_m = req.wide ? req.acc_in  : {{(ACC_W-BYTE_W){1'b0}}, req.acc_in[BYTE_W-1:0]};
   assign m_m = req.wide ? req.operand : {{(ACC_W-BYTE_W){1'b0}}, req.operand[BYTE_W-1:0]};

   // binary add with carry, subtract as add of the complement
   assign rhs     = sub ? (~m_m & (req.wide ? {ACC_W{1'b1}}
                                            : {{(ACC_W-BYTE_W){1'b0}}, {BYTE_W{1'b1}}}))
                        : m_m;
   assign bin_sum = {1'b0, a_m} + {1'b0, rhs} + {{ACC_W{1'b0}}, req.cin_flag};
   assign bin_res = req.wide ? bin_sum[ACC_W-1:0]
                             : {{(ACC_W-BYTE_W){1'b0}}, bin_sum[BYTE_W-1:0]};
   assign bin_cout = req.wide ? bin_sum[ACC_W] : bin_sum[BYTE_W];

   // two's-complement overflow at each width
   always_comb begin
      if (sub) begin
         v16 = (a_m[ACC_W-1] ^ m_m[ACC_W-1]) & (a_m[ACC_W-1] ^ bin_res[ACC_W-1]);
         v8  = (a_m[BYTE_W-1] ^ m_m[BYTE_W-1]) & (a_m[BYTE_W-1] ^ bin_res[BYTE_W-1]);
      end else begin
         v16 = (a_m[ACC_W-1] ^ bin_res[ACC_W-1]) & (m_m[ACC_W-1] ^ bin_res[ACC_W-1]);
         v8  = (a_m[BYTE_W-1] ^ bin_res[BYTE_W-1]) & (m_m[BYTE_W-1] ^ bin_res[BYTE_W-1]);
      end
      bin_v = req.wide ? v16 : v8;
   end

   // decimal ripple, one digit per step from the lowest nibble up
   always_comb begin
      logic [NIBBLE_W-1:0] na;
      logic [NIBBLE_W-1:0] nb;
      logic [NIBBLE_W:0]   t;
      logic [NIBBLE_W-1:0] d;
      logic                k;
      dec_res   = '0;
      dec_k_nar = 1'b0;
      k         = sub ? ~req.cin_flag : req.cin_flag;
      for (int i = 0; i < DIGITS; i++) begin
         na = a_m[i*NIBBLE_W +: NIBBLE_W];
         nb = m_m[i*NIBBLE_W +: NIBBLE_W];
         if (sub) begin
            t = {1'b0, na} - {1'b0, nb} - {{NIBBLE_W{1'b0}}, k};
            d = t[NIBBLE_W-1:0];
            if (t[NIBBLE_W]) begin
               d = d + DEC_SUB_ADJ;
               k = 1'b1;
            end else begin
               k = 1'b0;
            end
         end else begin
            t = {1'b0, na} + {1'b0, nb} + {{NIBBLE_W{1'b0}}, k};
            d = t[NIBBLE_W-1:0];
            if (t > DEC_MAX) begin
               d = d + DEC_ADD_ADJ;
               k = 1'b1;
            end else begin
               k = 1'b0;
            end
         end
         dec_res[i*NIBBLE_W +: NIBBLE_W] = d;
         if (i == DIGITS_NAR - 1) begin
            dec_k_nar = k;
         end
      end
      dec_k_wide = k;
   end

   assign dec_cout = sub ? ~(req.wide ? dec_k_wide : dec_k_nar)
                         :  (req.wide ? dec_k_wide : dec_k_nar);

   // result at active width and flags
   assign res = req.decimal ? (req.wide ? dec_res
                                        : {{(ACC_W-BYTE_W){1'b0}}, dec_res[BYTE_W-1:0]})
                            : bin_res;

   always_comb begin
      rsp.acc_out       = req.wide ? res : {req.acc_in[ACC_W-1:BYTE_W], res[BYTE_W-1:0]};
      rsp.cout_flag     = req.decimal ? dec_cout : bin_cout;
      rsp.zero_flag     = req.wide ? (res == '0) : (res[BYTE_W-1:0] == '0);
      rsp.negative_flag = req.wide ? res[ACC_W-1] : res[BYTE_W-1];
      rsp.overflow_out  = req.decimal ? req.overflow_in : bin_v;
   end

endmodule
